[hw/rtl/ovs_pkg.sv]
// ovs_pkg: widths, reset values and fixed-point constants for the orbit propagator.
// No dependencies; imported by orbit_verlet_step_top.
package ovs_pkg;

    localparam int PT_W           = 48;   // position / velocity word
    localparam int TIME_W         = 63;   // elapsed time word
    localparam int DT_W           = 32;   // step time word
    localparam int MU_W           = 50;   // gravitational parameter
    localparam int ACC_W          = 64;   // signed acceleration, LSB 2^-32
    localparam int TIME_FRAC_BITS = 20;
    localparam int ACC_FRAC_BITS  = 32;

    localparam logic [MU_W-1:0]   MU_RESET = 50'd398600441800000;
    localparam logic [62:0]       QMAX     = {63{1'b1}};
    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

endpackage

[hw/rtl/orbit_verlet_step_top.sv]
// orbit_verlet_step_top: velocity-Verlet two-body propagator on one shared wide adder.
// Depends on ovs_pkg.
//
//  channel | dir | handshake          | content
//  s_*     | in  | s_tvalid/s_tready  | tuser action, tdata step time and load state
//  m_*     | out | m_tvalid/m_tready  | tdata position, velocity, elapsed time
//  cfg_*   | in  | cfg_wr_en          | mu_gravity
//
// A load or a zero step is reported in the cycle after acceptance. In an advance,
// every multiply, square root and divide runs one bit per cycle through the single
// wide adder, and two gravity evaluations dominate its run time. Short operands end
// each multiply early, and a position near the centre skips the root and the divides.
// Reset clears position, velocity and time and sets mu to its default.
// The input is not ready from acceptance until the result item has been taken.
module orbit_verlet_step_top #(
    parameter int POS_FRAC_BITS = 16,
    parameter int VEL_FRAC_BITS = 24
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic                    s_tuser,      // action
    // step_time, load_pos_x, load_pos_y, load_pos_z, load_vel_x, load_vel_y, load_vel_z
    input  logic [319:0]            s_tdata,
    output logic                    m_tvalid,
    input  logic                    m_tready,
    // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, elapsed_time, one zero bit
    output logic [351:0]            m_tdata,
    input  logic                    cfg_wr_en,
    input  logic [ovs_pkg::MU_W-1:0] cfg_wr_data
);
    import ovs_pkg::*;

    // derived widths and shifts
    localparam int W      = 208 + POS_FRAC_BITS;
    localparam int R2_W   = 96;
    localparam int DEN_W  = 144 + POS_FRAC_BITS;
    localparam int SP     = ACC_FRAC_BITS + 2 * TIME_FRAC_BITS + 1;
    localparam int SV     = ACC_FRAC_BITS + TIME_FRAC_BITS + 1;
    localparam int SH_P   = SP - POS_FRAC_BITS;
    localparam int SH_VDT = SP - VEL_FRAC_BITS - TIME_FRAC_BITS;
    localparam int SH_V   = SV - VEL_FRAC_BITS;
    localparam int SH_NUM = 3 * POS_FRAC_BITS + ACC_FRAC_BITS;
    localparam int SQ_BIT = 94 + 2 * POS_FRAC_BITS;
    localparam logic [R2_W-1:0] NEAR_LIM =
        R2_W'((64'd1 << (2 * POS_FRAC_BITS)) / 64'd1000000);
    localparam logic [W-1:0] ONE_W = {{(W-1){1'b0}}, 1'b1};
    localparam logic [W-1:0] RND_P = ONE_W << (SH_P - 1);
    localparam logic [W-1:0] RND_V = ONE_W << (SH_V - 1);

    typedef enum logic [4:0] {
        S_IDLE, S_DT2, S_SQ_LD, S_SQ, S_SQRT, S_DEN, S_NUM_LD, S_NUM, S_DIV,
        S_P_LD, S_P_VDT, S_P_ADT, S_P_RND, S_V_LD, S_V_MUL, S_V_RND, S_OUT
    } state_t;

    state_t                 state_reg;
    logic [PT_W-1:0]        pos_reg [3];
    logic [PT_W-1:0]        vel_reg [3];
    logic [TIME_W-1:0]      time_reg;
    logic [MU_W-1:0]        mu_reg;
    logic [ACC_W-1:0]       a0_reg [3];
    logic [ACC_W-1:0]       a1_reg [3];
    logic [W-1:0]           acc_reg, opb_reg, opc_reg;
    logic [DEN_W-1:0]       den_reg;
    logic [R2_W-1:0]        r2_reg;
    logic [63:0]            dt2_reg;
    logic [DT_W-1:0]        dt_reg;
    logic [5:0]             cnt_reg;
    logic [1:0]             ax_reg;
    logic                   second_reg;
    logic                   msub_reg;

    function automatic logic [PT_W-1:0] abs48(input logic [PT_W-1:0] x);
        return x[PT_W-1] ? (~x + 1'b1) : x;
    endfunction

    function automatic logic [PT_W-1:0] sat48(input logic [W-1:0] x);
        if (x[W-1:PT_W-1] == {(W-PT_W+1){x[W-1]}})
            return x[PT_W-1:0];
        else
            return x[W-1] ? {1'b1, {(PT_W-1){1'b0}}} : {1'b0, {(PT_W-1){1'b1}}};
    endfunction

    // per-axis operand selection
    logic [PT_W-1:0]  pos_ax, vel_ax, pos_abs, vel_abs;
    logic [ACC_W-1:0] a0_ax, a1_ax, a0_abs;
    logic [ACC_W:0]   a_sum, a_sum_abs;
    logic [MU_W-1:0]  mu_eff;

    assign pos_ax    = pos_reg[ax_reg];
    assign vel_ax    = vel_reg[ax_reg];
    assign pos_abs   = abs48(pos_ax);
    assign vel_abs   = abs48(vel_ax);
    assign a0_ax     = a0_reg[ax_reg];
    assign a1_ax     = a1_reg[ax_reg];
    assign a0_abs    = a0_ax[ACC_W-1] ? (~a0_ax + 1'b1) : a0_ax;
    assign a_sum     = {a0_ax[ACC_W-1], a0_ax} + {a1_ax[ACC_W-1], a1_ax};
    assign a_sum_abs = a_sum[ACC_W] ? (~a_sum + 1'b1) : a_sum;
    assign mu_eff    = (mu_reg == '0) ? {{(MU_W-1){1'b0}}, 1'b1} : mu_reg;

    // shared wide adder / comparator
    logic [W-1:0] add_b;
    logic         add_sub;
    logic [W:0]   add_res;
    logic         add_ge;

    always_comb
    begin
        add_b   = opb_reg;
        add_sub = msub_reg;
        unique case (state_reg)
            S_SQRT:
            begin
                add_b   = opb_reg | opc_reg;
                add_sub = 1'b1;
            end
            S_DIV:
            begin
                add_sub = 1'b1;
            end
            S_P_RND:
            begin
                add_b   = RND_P;
                add_sub = 1'b0;
            end
            S_V_RND:
            begin
                add_b   = RND_V;
                add_sub = 1'b0;
            end
            default:
            begin
                add_b   = opb_reg;
                add_sub = msub_reg;
            end
        endcase
    end

    assign add_res = add_sub ? ({1'b0, acc_reg} - {1'b0, add_b})
                             : ({1'b0, acc_reg} + {1'b0, add_b});
    assign add_ge  = ~add_res[W];

    // rounded, shifted results and quotient
    logic signed [W-1:0] p_sh, v_sh;
    logic [62:0]         div_q;
    logic [ACC_W-1:0]    a_new;
    logic                div_end, mul_done;
    logic [TIME_W:0]     t_sum;

    assign p_sh     = $signed(add_res[W-1:0]) >>> SH_P;
    assign v_sh     = $signed(add_res[W-1:0]) >>> SH_V;
    assign div_q    = (cnt_reg == 6'd63) ? QMAX : {opc_reg[61:0], add_ge};
    assign a_new    = pos_ax[PT_W-1] ? {1'b0, div_q} : (~{1'b0, div_q} + 1'b1);
    assign div_end  = ((cnt_reg == 6'd63) && add_ge) || (cnt_reg == 6'd0);
    assign mul_done = (opc_reg == '0);
    assign t_sum    = {1'b0, time_reg} + {{(TIME_W+1-DT_W){1'b0}}, dt_reg};

    // sequencer and datapath registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            for (int i = 0; i < 3; i++)
            begin
                pos_reg[i] <= '0;
                vel_reg[i] <= '0;
                a0_reg[i]  <= '0;
                a1_reg[i]  <= '0;
            end
            time_reg   <= '0;
            mu_reg     <= MU_RESET;
            acc_reg    <= '0;
            opb_reg    <= '0;
            opc_reg    <= '0;
            den_reg    <= '0;
            r2_reg     <= '0;
            dt2_reg    <= '0;
            dt_reg     <= '0;
            cnt_reg    <= '0;
            ax_reg     <= '0;
            second_reg <= 1'b0;
            msub_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
                mu_reg <= cfg_wr_data;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        if (s_tuser)
                        begin
                            pos_reg[0] <= s_tdata[79:32];
                            pos_reg[1] <= s_tdata[127:80];
                            pos_reg[2] <= s_tdata[175:128];
                            vel_reg[0] <= s_tdata[223:176];
                            vel_reg[1] <= s_tdata[271:224];
                            vel_reg[2] <= s_tdata[319:272];
                            time_reg   <= '0;
                            state_reg  <= S_OUT;
                        end
                        else if (s_tdata[31:0] == '0)
                            state_reg <= S_OUT;
                        else
                        begin
                            dt_reg    <= s_tdata[31:0];
                            acc_reg   <= '0;
                            opb_reg   <= W'(s_tdata[31:0]);
                            opc_reg   <= W'(s_tdata[31:0]);
                            msub_reg  <= 1'b0;
                            state_reg <= S_DT2;
                        end
                    end
                end

                S_DT2:
                begin
                    if (mul_done)
                    begin
                        dt2_reg    <= acc_reg[63:0];
                        ax_reg     <= '0;
                        second_reg <= 1'b0;
                        acc_reg    <= '0;
                        state_reg  <= S_SQ_LD;
                    end
                    else
                    begin
                        if (opc_reg[0]) acc_reg <= add_res[W-1:0];
                        opb_reg <= opb_reg << 1;
                        opc_reg <= opc_reg >> 1;
                    end
                end

                // |p|^2 summed into acc over the three axes
                S_SQ_LD:
                begin
                    opb_reg   <= W'(pos_abs);
                    opc_reg   <= W'(pos_abs);
                    msub_reg  <= 1'b0;
                    state_reg <= S_SQ;
                end

                S_SQ:
                begin
                    if (mul_done)
                    begin
                        if (ax_reg != 2'd2)
                        begin
                            ax_reg    <= ax_reg + 2'd1;
                            state_reg <= S_SQ_LD;
                        end
                        else
                        begin
                            r2_reg <= acc_reg[R2_W-1:0];
                            ax_reg <= '0;
                            if (acc_reg[R2_W-1:0] <= NEAR_LIM)
                            begin
                                for (int i = 0; i < 3; i++)
                                begin
                                    if (second_reg) a1_reg[i] <= '0;
                                    else            a0_reg[i] <= '0;
                                end
                                state_reg <= second_reg ? S_V_LD : S_P_LD;
                            end
                            else
                            begin
                                acc_reg   <= acc_reg << (2 * POS_FRAC_BITS);
                                opb_reg   <= '0;
                                opc_reg   <= ONE_W << SQ_BIT;
                                state_reg <= S_SQRT;
                            end
                        end
                    end
                    else
                    begin
                        if (opc_reg[0]) acc_reg <= add_res[W-1:0];
                        opb_reg <= opb_reg << 1;
                        opc_reg <= opc_reg >> 1;
                    end
                end

                // digit-by-digit square root: opb root, opc trial bit
                S_SQRT:
                begin
                    if (opc_reg == '0)
                    begin
                        acc_reg   <= '0;
                        opb_reg   <= W'(r2_reg);
                        opc_reg   <= opb_reg;
                        msub_reg  <= 1'b0;
                        state_reg <= S_DEN;
                    end
                    else
                    begin
                        if (add_ge)
                        begin
                            acc_reg <= add_res[W-1:0];
                            opb_reg <= (opb_reg >> 1) | opc_reg;
                        end
                        else
                            opb_reg <= opb_reg >> 1;
                        opc_reg <= opc_reg >> 2;
                    end
                end

                // denominator R2 * S
                S_DEN:
                begin
                    if (mul_done)
                    begin
                        den_reg   <= acc_reg[DEN_W-1:0];
                        ax_reg    <= '0;
                        state_reg <= S_NUM_LD;
                    end
                    else
                    begin
                        if (opc_reg[0]) acc_reg <= add_res[W-1:0];
                        opb_reg <= opb_reg << 1;
                        opc_reg <= opc_reg >> 1;
                    end
                end

                S_NUM_LD:
                begin
                    acc_reg   <= '0;
                    opb_reg   <= W'(mu_eff);
                    opc_reg   <= W'(pos_abs);
                    state_reg <= S_NUM;
                end

                S_NUM:
                begin
                    if (mul_done)
                    begin
                        acc_reg   <= acc_reg << SH_NUM;
                        opb_reg   <= {{(W-DEN_W){1'b0}}, den_reg} << 63;
                        opc_reg   <= '0;
                        cnt_reg   <= 6'd63;
                        state_reg <= S_DIV;
                    end
                    else
                    begin
                        if (opc_reg[0]) acc_reg <= add_res[W-1:0];
                        opb_reg <= opb_reg << 1;
                        opc_reg <= opc_reg >> 1;
                    end
                end

                // restoring divide; first compare is the overflow test for the cap
                S_DIV:
                begin
                    if (div_end)
                    begin
                        if (second_reg) a1_reg[ax_reg] <= a_new;
                        else            a0_reg[ax_reg] <= a_new;
                        if (ax_reg != 2'd2)
                        begin
                            ax_reg    <= ax_reg + 2'd1;
                            state_reg <= S_NUM_LD;
                        end
                        else
                        begin
                            ax_reg    <= '0;
                            state_reg <= second_reg ? S_V_LD : S_P_LD;
                        end
                    end
                    else
                    begin
                        if (add_ge) acc_reg <= add_res[W-1:0];
                        opc_reg <= {opc_reg[W-2:0], add_ge};
                        opb_reg <= opb_reg >> 1;
                        cnt_reg <= cnt_reg - 6'd1;
                    end
                end

                // position: p + v*dt + a0*dt^2/2
                S_P_LD:
                begin
                    acc_reg   <= {{(W-PT_W){pos_ax[PT_W-1]}}, pos_ax} << SH_P;
                    opb_reg   <= W'(vel_abs) << SH_VDT;
                    opc_reg   <= W'(dt_reg);
                    msub_reg  <= vel_ax[PT_W-1];
                    state_reg <= S_P_VDT;
                end

                S_P_VDT:
                begin
                    if (mul_done)
                    begin
                        opb_reg   <= W'(a0_abs);
                        opc_reg   <= W'(dt2_reg);
                        msub_reg  <= a0_ax[ACC_W-1];
                        state_reg <= S_P_ADT;
                    end
                    else
                    begin
                        if (opc_reg[0]) acc_reg <= add_res[W-1:0];
                        opb_reg <= opb_reg << 1;
                        opc_reg <= opc_reg >> 1;
                    end
                end

                S_P_ADT:
                begin
                    if (mul_done)
                        state_reg <= S_P_RND;
                    else
                    begin
                        if (opc_reg[0]) acc_reg <= add_res[W-1:0];
                        opb_reg <= opb_reg << 1;
                        opc_reg <= opc_reg >> 1;
                    end
                end

                S_P_RND:
                begin
                    pos_reg[ax_reg] <= sat48(p_sh);
                    if (ax_reg != 2'd2)
                    begin
                        ax_reg    <= ax_reg + 2'd1;
                        state_reg <= S_P_LD;
                    end
                    else
                    begin
                        second_reg <= 1'b1;
                        ax_reg     <= '0;
                        acc_reg    <= '0;
                        state_reg  <= S_SQ_LD;
                    end
                end

                // velocity: v + (a0 + a1)*dt/2
                S_V_LD:
                begin
                    acc_reg   <= {{(W-PT_W){vel_ax[PT_W-1]}}, vel_ax} << SH_V;
                    opb_reg   <= W'(a_sum_abs);
                    opc_reg   <= W'(dt_reg);
                    msub_reg  <= a_sum[ACC_W];
                    state_reg <= S_V_MUL;
                end

                S_V_MUL:
                begin
                    if (mul_done)
                        state_reg <= S_V_RND;
                    else
                    begin
                        if (opc_reg[0]) acc_reg <= add_res[W-1:0];
                        opb_reg <= opb_reg << 1;
                        opc_reg <= opc_reg >> 1;
                    end
                end

                S_V_RND:
                begin
                    vel_reg[ax_reg] <= sat48(v_sh);
                    if (ax_reg != 2'd2)
                    begin
                        ax_reg    <= ax_reg + 2'd1;
                        state_reg <= S_V_LD;
                    end
                    else
                    begin
                        time_reg  <= t_sum[TIME_W] ? TIME_MAX : t_sum[TIME_W-1:0];
                        state_reg <= S_OUT;
                    end
                end

                S_OUT:
                begin
                    if (m_tready)
                        state_reg <= S_IDLE;
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // ports
    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = (state_reg == S_OUT);
    assign m_tdata  = {1'b0, time_reg, vel_reg[2], vel_reg[1], vel_reg[0],
                       pos_reg[2], pos_reg[1], pos_reg[0]};

endmodule
